// ===== design/dpd_pkg.sv =====
`default_nettype none

package dpd_pkg;

  // frame geometry
  localparam int FRAME_WIDTH  = 640;
  localparam int FRAME_HEIGHT = 480;
  localparam int FRAME_DEPTH  = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int ADDR_W       = $clog2(FRAME_DEPTH);

  // field widths
  localparam int COL_W    = 10;
  localparam int ROW_W    = 9;
  localparam int DEPTH_W  = 16;
  localparam int CFG_W    = 16;
  localparam int WIN_W    = 8;
  localparam int CIDX_W   = 3;
  localparam int STAT_W   = 2;
  localparam int COORD_W  = 32;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 96;

  // signed search column, wide enough for col plus or minus a full window
  localparam int SCOL_W = COL_W + 2;

  // iterative divider
  localparam int DIV_STEPS = COORD_W;
  localparam int DIVC_W    = $clog2(DIV_STEPS);

  // register indexes
  localparam logic [CIDX_W-1:0] REG_FOCAL_X  = 3'd0;
  localparam logic [CIDX_W-1:0] REG_FOCAL_Y  = 3'd1;
  localparam logic [CIDX_W-1:0] REG_CENTER_X = 3'd2;
  localparam logic [CIDX_W-1:0] REG_CENTER_Y = 3'd3;
  localparam logic [CIDX_W-1:0] REG_WINDOW   = 3'd4;

  // register reset values
  localparam logic [CFG_W-1:0] RST_FOCAL_X  = 16'd9600;
  localparam logic [CFG_W-1:0] RST_FOCAL_Y  = 16'd9600;
  localparam logic [CFG_W-1:0] RST_CENTER_X = 16'd5120;
  localparam logic [CFG_W-1:0] RST_CENTER_Y = 16'd3840;
  localparam logic [WIN_W-1:0] RST_WINDOW   = 8'd20;

  // commands
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // result status codes
  localparam logic [STAT_W-1:0] STATUS_FOUND    = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_NO_DEPTH = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_OUT      = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic              clear;
    logic              wr_en;
    logic              cap_query;
    logic              set_status;
    logic [STAT_W-1:0] status_code;
    logic              issue;
    logic              capture_hit;
    logic              div_load;
    logic              axis;
    logic              div_step;
    logic              store_x;
    logic              store_y;
    logic              load_out;
  } dpd_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last;
    logic in_frame;
    logic win_zero;
    logic issue_last;
    logic hit;
  } dpd_sts_t;

endpackage

`default_nettype wire

// ===== design/dpd_ctrl.sv =====
`default_nettype none

module dpd_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  input  wire logic              in_tuser,
  input  wire logic              out_tready,
  input  wire dpd_pkg::dpd_sts_t sts,
  output dpd_pkg::dpd_cmd_t      cmd,
  output logic                   in_tready,
  output logic                   out_tvalid
);

  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_SEARCH = 4'd2;
  localparam logic [3:0] S_DRAIN  = 4'd3;
  localparam logic [3:0] S_MULX   = 4'd4;
  localparam logic [3:0] S_DIVX   = 4'd5;
  localparam logic [3:0] S_MULY   = 4'd6;
  localparam logic [3:0] S_DIVY   = 4'd7;
  localparam logic [3:0] S_SATY   = 4'd8;
  localparam logic [3:0] S_DONE   = 4'd9;

  logic [3:0]                 state_r, state_nxt;
  logic [dpd_pkg::DIVC_W-1:0] divc_r, divc_nxt;
  logic                       outv_r, outv_nxt;
  logic                       accept;
  logic                       div_last;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = outv_r;
  assign accept     = in_tvalid && in_tready;
  assign div_last   = (divc_r == dpd_pkg::DIVC_W'(dpd_pkg::DIV_STEPS - 1));

  always_comb begin
    state_nxt = state_r;
    divc_nxt  = divc_r;
    cmd       = '0;
    case (state_r)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          if (in_tuser == dpd_pkg::CMD_WRITE) begin
            cmd.wr_en = 1'b1;
          end else begin
            cmd.cap_query = 1'b1;
            if (!sts.in_frame) begin
              cmd.set_status  = 1'b1;
              cmd.status_code = dpd_pkg::STATUS_OUT;
              state_nxt       = S_DONE;
            end else if (sts.win_zero) begin
              cmd.set_status  = 1'b1;
              cmd.status_code = dpd_pkg::STATUS_NO_DEPTH;
              state_nxt       = S_DONE;
            end else begin
              state_nxt = S_SEARCH;
            end
          end
        end
      end
      S_SEARCH: begin
        cmd.issue = 1'b1;
        if (sts.hit) begin
          cmd.capture_hit = 1'b1;
          state_nxt       = S_MULX;
        end else if (sts.issue_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (sts.hit) begin
          cmd.capture_hit = 1'b1;
          state_nxt       = S_MULX;
        end else begin
          cmd.set_status  = 1'b1;
          cmd.status_code = dpd_pkg::STATUS_NO_DEPTH;
          state_nxt       = S_DONE;
        end
      end
      S_MULX: begin
        cmd.div_load = 1'b1;
        cmd.axis     = 1'b0;
        divc_nxt     = '0;
        state_nxt    = S_DIVX;
      end
      S_DIVX: begin
        cmd.div_step = 1'b1;
        divc_nxt     = divc_r + 1'b1;
        if (div_last) begin
          state_nxt = S_MULY;
        end
      end
      S_MULY: begin
        // x quotient is read out while the y product loads
        cmd.store_x  = 1'b1;
        cmd.div_load = 1'b1;
        cmd.axis     = 1'b1;
        divc_nxt     = '0;
        state_nxt    = S_DIVY;
      end
      S_DIVY: begin
        cmd.div_step = 1'b1;
        divc_nxt     = divc_r + 1'b1;
        if (div_last) begin
          state_nxt = S_SATY;
        end
      end
      S_SATY: begin
        cmd.store_y = 1'b1;
        state_nxt   = S_DONE;
      end
      S_DONE: begin
        if (!outv_r || out_tready) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.load_out) begin
      outv_nxt = 1'b1;
    end else if (out_tready) begin
      outv_nxt = 1'b0;
    end else begin
      outv_nxt = outv_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      divc_r  <= '0;
      outv_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      divc_r  <= divc_nxt;
      outv_r  <= outv_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== design/dpd_datapath.sv =====
`default_nettype none

module dpd_datapath (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic [dpd_pkg::COL_W-1:0]         in_col,
  input  wire logic [dpd_pkg::ROW_W-1:0]         in_row,
  input  wire logic [dpd_pkg::DEPTH_W-1:0]       in_depth,
  input  wire logic                              cfg_we,
  input  wire logic [dpd_pkg::CIDX_W-1:0]        cfg_index,
  input  wire logic [dpd_pkg::CFG_W-1:0]         cfg_data,
  input  wire dpd_pkg::dpd_cmd_t                 cmd,
  output dpd_pkg::dpd_sts_t                      sts,
  output logic [dpd_pkg::STAT_W-1:0]             out_status,
  output logic signed [dpd_pkg::COORD_W-1:0]     out_x,
  output logic signed [dpd_pkg::COORD_W-1:0]     out_y,
  output logic [dpd_pkg::DEPTH_W-1:0]            out_z,
  output logic [dpd_pkg::COL_W-1:0]              out_col
);

  localparam int AW   = dpd_pkg::ADDR_W;
  localparam int CW   = dpd_pkg::COL_W;
  localparam int RW   = dpd_pkg::ROW_W;
  localparam int DW   = dpd_pkg::DEPTH_W;
  localparam int SW   = dpd_pkg::SCOL_W;
  localparam int QW   = dpd_pkg::COORD_W;
  localparam int FW   = dpd_pkg::CFG_W;
  localparam int WW   = dpd_pkg::WIN_W;
  localparam int DIFW = FW + 1;

  // configuration
  logic [FW-1:0] focal_x_r, focal_y_r, center_x_r, center_y_r;
  logic [WW-1:0] win_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      focal_x_r  <= dpd_pkg::RST_FOCAL_X;
      focal_y_r  <= dpd_pkg::RST_FOCAL_Y;
      center_x_r <= dpd_pkg::RST_CENTER_X;
      center_y_r <= dpd_pkg::RST_CENTER_Y;
      win_r      <= dpd_pkg::RST_WINDOW;
    end else if (cfg_we) begin
      case (cfg_index)
        dpd_pkg::REG_FOCAL_X:  focal_x_r  <= cfg_data;
        dpd_pkg::REG_FOCAL_Y:  focal_y_r  <= cfg_data;
        dpd_pkg::REG_CENTER_X: center_x_r <= cfg_data;
        dpd_pkg::REG_CENTER_Y: center_y_r <= cfg_data;
        dpd_pkg::REG_WINDOW:   win_r      <= cfg_data[WW-1:0];
        default: ;
      endcase
    end
  end

  // input pixel address
  logic          in_frame;
  logic [AW-1:0] in_base;
  logic [AW-1:0] in_addr;

  assign in_frame = (in_col < CW'(dpd_pkg::FRAME_WIDTH)) && (in_row < RW'(dpd_pkg::FRAME_HEIGHT));
  assign in_base  = AW'(in_row) * AW'(dpd_pkg::FRAME_WIDTH);
  assign in_addr  = in_base + AW'(in_col);

  // clearing sweep after reset
  logic [AW-1:0] clr_addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
    end else if (cmd.clear && clr_addr_r != AW'(dpd_pkg::FRAME_DEPTH - 1)) begin
      clr_addr_r <= clr_addr_r + 1'b1;
    end
  end

  // query capture and ring sequencer
  logic [CW-1:0] q_col_r;
  logic [RW-1:0] q_row_r;
  logic [AW-1:0] q_base_r;
  logic [WW-1:0] ring_r;
  logic          side_r;
  logic signed [SW-1:0] pos;
  logic          pos_ok;
  logic [AW-1:0] rd_addr;

  // left side first, which keeps the leftmost hit within a ring
  assign pos = side_r ? (SW'(q_col_r) + SW'(ring_r)) : (SW'(q_col_r) - SW'(ring_r));
  assign pos_ok  = (pos >= 0) && (pos < SW'(dpd_pkg::FRAME_WIDTH));
  assign rd_addr = q_base_r + AW'(pos[CW-1:0]);

  always_ff @(posedge clk) begin
    if (cmd.cap_query) begin
      q_col_r  <= in_col;
      q_row_r  <= in_row;
      q_base_r <= in_base;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ring_r <= '0;
      side_r <= 1'b0;
    end else if (cmd.cap_query) begin
      ring_r <= '0;
      side_r <= 1'b0;
    end else if (cmd.issue) begin
      if (ring_r == '0 || side_r) begin
        ring_r <= ring_r + 1'b1;
        side_r <= 1'b0;
      end else begin
        side_r <= 1'b1;
      end
    end
  end

  // frame store
  logic [DW-1:0] mem [dpd_pkg::FRAME_DEPTH];
  logic [DW-1:0] rd_data_r;
  logic          tag_v_r;
  logic [CW-1:0] tag_col_r;
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic [DW-1:0] mem_wd;

  assign mem_we = cmd.clear || (cmd.wr_en && in_frame);
  assign mem_wa = cmd.clear ? clr_addr_r : in_addr;
  assign mem_wd = cmd.clear ? '0 : in_depth;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (cmd.issue) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_v_r <= 1'b0;
    end else begin
      tag_v_r <= cmd.issue && pos_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      tag_col_r <= pos[CW-1:0];
    end
  end

  // found sample
  logic [CW-1:0] fcol_r;
  logic [DW-1:0] z_r;

  always_ff @(posedge clk) begin
    if (cmd.capture_hit) begin
      fcol_r <= tag_col_r;
      z_r    <= rd_data_r;
    end
  end

  function automatic logic [FW-1:0] q_select_pos(input logic axis,
                                                 input logic [CW-1:0] c,
                                                 input logic [RW-1:0] r);
    logic [FW-1:0] v;
    if (axis) begin
      v = FW'({r, 4'b0000});
    end else begin
      v = FW'({c, 4'b0000});
    end
    return v;
  endfunction

  // offset from the principal point, then |offset| * z into the divider
  logic [FW-1:0]          pos16;
  logic [FW-1:0]          center;
  logic signed [DIFW-1:0] diff;
  logic                   diff_neg;
  logic [FW-1:0]          mag;
  logic [QW-1:0]          prod;

  assign pos16    = q_select_pos(cmd.axis, fcol_r, q_row_r);
  assign center   = cmd.axis ? center_y_r : center_x_r;
  assign diff     = $signed({1'b0, pos16}) - $signed({1'b0, center});
  assign diff_neg = diff[DIFW-1];
  assign mag      = diff_neg ? FW'(-diff) : FW'(diff);
  assign prod     = QW'(mag) * QW'(z_r);

  // restoring divider, one quotient bit a cycle
  logic [QW-1:0] quo_r;
  logic [FW-1:0] rem_r;
  logic          neg_r;
  logic          zero_r;
  logic          axis_r;
  logic [FW-1:0] focal;
  logic [FW:0]   rem_sh;
  logic          ge;

  assign focal  = axis_r ? focal_y_r : focal_x_r;
  assign rem_sh = {rem_r, quo_r[QW-1]};
  assign ge     = (rem_sh >= {1'b0, focal});

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      quo_r  <= prod;
      rem_r  <= '0;
      neg_r  <= diff_neg;
      zero_r <= (prod == '0);
      axis_r <= cmd.axis;
    end else if (cmd.div_step) begin
      quo_r <= {quo_r[QW-2:0], ge};
      rem_r <= ge ? FW'(rem_sh - {1'b0, focal}) : rem_sh[FW-1:0];
    end
  end

  // truncated quotient with sign, saturated to the signed range
  function automatic logic [QW-1:0] sat_coord(input logic [QW-1:0] q,
                                              input logic neg,
                                              input logic zero);
    logic [QW-1:0] v;
    if (zero) begin
      v = '0;
    end else if (!neg) begin
      v = q[QW-1] ? {1'b0, {(QW-1){1'b1}}} : q;
    end else begin
      v = (q > {1'b1, {(QW-1){1'b0}}}) ? {1'b1, {(QW-1){1'b0}}} : (~q + 1'b1);
    end
    return v;
  endfunction

  logic [QW-1:0]              px_r, py_r;
  logic [dpd_pkg::STAT_W-1:0] res_status_r;

  always_ff @(posedge clk) begin
    if (cmd.store_x) begin
      px_r <= sat_coord(quo_r, neg_r, zero_r);
    end
    if (cmd.store_y) begin
      py_r <= sat_coord(quo_r, neg_r, zero_r);
    end
    if (cmd.capture_hit) begin
      res_status_r <= dpd_pkg::STATUS_FOUND;
    end else if (cmd.set_status) begin
      res_status_r <= cmd.status_code;
    end
  end

  // output register
  logic [dpd_pkg::STAT_W-1:0] o_status_r;
  logic [QW-1:0]              o_x_r, o_y_r;
  logic [DW-1:0]              o_z_r;
  logic [CW-1:0]              o_col_r;
  logic                       res_found;

  assign res_found = (res_status_r == dpd_pkg::STATUS_FOUND);

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      o_status_r <= res_status_r;
      o_x_r      <= res_found ? px_r : '0;
      o_y_r      <= res_found ? py_r : '0;
      o_z_r      <= res_found ? z_r : '0;
      o_col_r    <= res_found ? fcol_r : '0;
    end
  end

  assign out_status = o_status_r;
  assign out_x      = $signed(o_x_r);
  assign out_y      = $signed(o_y_r);
  assign out_z      = o_z_r;
  assign out_col    = o_col_r;

  assign sts.clr_last   = (clr_addr_r == AW'(dpd_pkg::FRAME_DEPTH - 1));
  assign sts.in_frame   = in_frame;
  assign sts.win_zero   = (win_r == '0);
  assign sts.issue_last = (ring_r == win_r - 1'b1) && (ring_r == '0 || side_r);
  assign sts.hit        = tag_v_r && (rd_data_r != '0);

endmodule

`default_nettype wire

// ===== design/depth_pixel_deprojection.sv =====
// write beat: one write per cycle while idle
// query: an accept, at most 2*search_window-1 frame store reads (one read port), a drain when no
//   earlier read hit, then per axis a multiply and 32 divider steps, a saturate, an output load
// out of frame or empty window: the accept sets the status and goes straight to the output load
// the output register frees the input side while a result waits
// synchronous active-low reset; then the frame store is cleared to zero, no beat taken
`default_nettype none

module depth_pixel_deprojection (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  // pixel_col [9:0], pixel_row [18:10], depth_mm [34:19], zero fill above
  input  wire logic [dpd_pkg::IN_TDATA_W-1:0]      in_tdata,
  // command [0]
  input  wire logic                                in_tuser,
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  // point_x_mm [31:0], point_y_mm [63:32], point_z_mm [79:64], found_col [89:80], zero fill
  output logic [dpd_pkg::OUT_TDATA_W-1:0]          out_tdata,
  // status [1:0]
  output logic [dpd_pkg::STAT_W-1:0]               out_tuser,
  input  wire logic                                cfg_we,
  input  wire logic [dpd_pkg::CIDX_W-1:0]          cfg_index,
  input  wire logic [dpd_pkg::CFG_W-1:0]           cfg_data
);

  dpd_pkg::dpd_cmd_t cmd;
  dpd_pkg::dpd_sts_t sts;

  logic signed [dpd_pkg::COORD_W-1:0] out_x, out_y;
  logic [dpd_pkg::DEPTH_W-1:0]        out_z;
  logic [dpd_pkg::COL_W-1:0]          out_col;

  dpd_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tuser   (in_tuser),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid)
  );

  dpd_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_col     (in_tdata[9:0]),
    .in_row     (in_tdata[18:10]),
    .in_depth   (in_tdata[34:19]),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .sts        (sts),
    .out_status (out_tuser),
    .out_x      (out_x),
    .out_y      (out_y),
    .out_z      (out_z),
    .out_col    (out_col)
  );

  assign out_tdata = {6'b000000, out_col, out_z, out_y, out_x};

endmodule

`default_nettype wire

// ===== design/dpd_checker.sv =====
`default_nettype none

module dpd_checker (
  input wire logic                                clk,
  input wire logic                                rst_n,
  input wire logic                                in_tready,
  input wire logic                                out_tvalid,
  input wire logic                                out_tready,
  input wire logic [dpd_pkg::OUT_TDATA_W-1:0]     out_tdata,
  input wire logic [dpd_pkg::STAT_W-1:0]          out_tuser
);

  // a stalled result beat stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result beat dropped while stalled");

  // only a found point carries coordinates
  a_zero_unless_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != dpd_pkg::STATUS_FOUND |-> out_tdata == '0)
    else $error("nonzero payload on a result that found nothing");

  // a found point always has a nonzero depth
  a_found_depth: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == dpd_pkg::STATUS_FOUND |-> out_tdata[79:64] != '0)
    else $error("found point with zero depth");

  // reset starts the clearing sweep: nothing taken, nothing offered
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !in_tready && !out_tvalid)
    else $error("beat handshake active right after reset");

endmodule

bind depth_pixel_deprojection dpd_checker u_dpd_checker (.*);

`default_nettype wire

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import dpd_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 4_000_000;
  localparam int unsigned RANDOM_BEATS = 1300;
  localparam longint SAT_HI = 64'sd2147483647;
  localparam longint SAT_LO = -64'sd2147483648;

  typedef struct {
    logic [STAT_W-1:0]         status;
    logic signed [COORD_W-1:0] x_mm;
    logic signed [COORD_W-1:0] y_mm;
    logic [DEPTH_W-1:0]        z_mm;
    logic [COL_W-1:0]          col;
  } point_rec_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [STAT_W-1:0]      out_tuser;
  logic                   cfg_we;
  logic [CIDX_W-1:0]      cfg_index;
  logic [CFG_W-1:0]       cfg_data;

  depth_pixel_deprojection dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // shadow of the frame store and the camera registers
  bit [DEPTH_W-1:0] depth_img [FRAME_DEPTH];
  logic [CFG_W-1:0] cam_fx  = RST_FOCAL_X;
  logic [CFG_W-1:0] cam_fy  = RST_FOCAL_Y;
  logic [CFG_W-1:0] cam_cx  = RST_CENTER_X;
  logic [CFG_W-1:0] cam_cy  = RST_CENTER_Y;
  logic [WIN_W-1:0] cam_win = RST_WINDOW;

  point_rec_t  pending_points [$];
  int unsigned fail_count    = 0;
  int unsigned cycle_count   = 0;
  int unsigned beats_counted = 0;
  bit          steady_flow   = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady_flow || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic signed [COORD_W-1:0] to_mm(input int unsigned pos,
      input logic [CFG_W-1:0] centre, input logic [CFG_W-1:0] focal,
      input logic [DEPTH_W-1:0] z);
    longint num;
    longint q;
    num = (longint'(pos) * 16 - longint'(centre)) * longint'(z);
    if (focal == 0)
      q = (num > 0) ? SAT_HI : ((num < 0) ? SAT_LO : 0);
    else
      q = num / longint'(focal);
    if (q > SAT_HI) q = SAT_HI;
    if (q < SAT_LO) q = SAT_LO;
    return q[COORD_W-1:0];
  endfunction

  function automatic point_rec_t deproject_query(input logic [COL_W-1:0] col,
                                                 input logic [ROW_W-1:0] row);
    point_rec_t res;
    int r, lo, hi, base, fc;
    bit hit;
    logic [DEPTH_W-1:0] z;
    res.status = STATUS_OUT;
    res.x_mm   = '0;
    res.y_mm   = '0;
    res.z_mm   = '0;
    res.col    = '0;
    if (col >= FRAME_WIDTH || row >= FRAME_HEIGHT) return res;
    res.status = STATUS_NO_DEPTH;
    base = int'(row) * FRAME_WIDTH;
    hit  = 1'b0;
    fc   = 0;
    // each ring only adds its two end columns, the inner ones were empty a ring earlier
    for (r = 0; r < int'(cam_win) && !hit; r++) begin
      lo = int'(col) - r;
      hi = int'(col) + r;
      if (lo >= 0 && depth_img[base + lo] != 0) begin
        hit = 1'b1;
        fc  = lo;
      end else if (hi < FRAME_WIDTH && depth_img[base + hi] != 0) begin
        hit = 1'b1;
        fc  = hi;
      end
    end
    if (!hit) return res;
    z          = depth_img[base + fc];
    res.status = STATUS_FOUND;
    res.x_mm   = to_mm(fc, cam_cx, cam_fx, z);
    res.y_mm   = to_mm(row, cam_cy, cam_fy, z);
    res.z_mm   = z;
    res.col    = fc[COL_W-1:0];
    return res;
  endfunction

  task automatic send_beat(input logic cmd, input logic [COL_W-1:0] col,
                           input logic [ROW_W-1:0] row, input logic [DEPTH_W-1:0] dep);
    int unsigned gap;
    gap = idle_len();
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= IN_TDATA_W'({dep, row, col});
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (cmd == CMD_QUERY) begin
      pending_points.push_back(deproject_query(col, row));
      beats_counted++;
    end else if (col < FRAME_WIDTH && row < FRAME_HEIGHT) begin
      depth_img[int'(row) * FRAME_WIDTH + int'(col)] = dep;
      beats_counted++;
    end
  endtask

  task automatic put_depth(input logic [COL_W-1:0] col, input logic [ROW_W-1:0] row,
                           input logic [DEPTH_W-1:0] dep);
    send_beat(CMD_WRITE, col, row, dep);
  endtask

  task automatic ask_point(input logic [COL_W-1:0] col, input logic [ROW_W-1:0] row);
    send_beat(CMD_QUERY, col, row, DEPTH_W'($urandom));
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk);
    // a trailing pixel write may still be landing
    repeat (8) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CIDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_FOCAL_X:  cam_fx  = data;
      REG_FOCAL_Y:  cam_fy  = data;
      REG_CENTER_X: cam_cx  = data;
      REG_CENTER_Y: cam_cy  = data;
      REG_WINDOW:   cam_win = data[WIN_W-1:0];
      default: ;
    endcase
  endtask

  task automatic program_camera(input logic [CFG_W-1:0] fx, input logic [CFG_W-1:0] fy,
                                input logic [CFG_W-1:0] cx, input logic [CFG_W-1:0] cy,
                                input logic [CFG_W-1:0] win);
    drain_results();
    cfg_write(REG_FOCAL_X, fx);
    cfg_write(REG_FOCAL_Y, fy);
    cfg_write(REG_CENTER_X, cx);
    cfg_write(REG_CENTER_Y, cy);
    cfg_write(REG_WINDOW, win);
  endtask

  task automatic test_frame_edges();
    ask_point(10'd320, 9'd240);
    ask_point(COL_W'(FRAME_WIDTH), 9'd0);
    ask_point(10'd0, ROW_W'(FRAME_HEIGHT));
    ask_point('1, '1);
    // writes outside the frame leave the store alone
    put_depth(10'd700, 9'd10, 16'd5);
    put_depth('1, '1, '1);
    ask_point(10'd639, 9'd10);
    put_depth(10'd0, 9'd0, 16'hFFFF);
    ask_point(10'd0, 9'd0);
    put_depth(10'd639, 9'd479, 16'd1);
    ask_point(10'd639, 9'd479);
    // search clipped at the left and at the right edge
    put_depth(10'd5, 9'd100, 16'd1234);
    ask_point(10'd0, 9'd100);
    put_depth(10'd639, 9'd200, 16'd777);
    ask_point(10'd630, 9'd200);
    // both ends of one ring hold depth, the left one wins
    put_depth(10'd300, 9'd50, 16'd11);
    put_depth(10'd310, 9'd50, 16'd22);
    ask_point(10'd305, 9'd50);
    put_depth(10'd320, 9'd240, 16'd500);
    ask_point(10'd320, 9'd240);
    put_depth(10'd320, 9'd240, 16'd0);
    ask_point(10'd320, 9'd240);
  endtask

  task automatic test_register_extremes();
    int idx;
    program_camera(16'd1, 16'd1, 16'd0, 16'd0, 16'd1);
    ask_point(10'd639, 9'd479);
    ask_point(10'd638, 9'd479);
    ask_point(10'd0, 9'd0);
    // widest window, centre far off: lateral result saturates negative
    program_camera(16'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    ask_point(10'd0, 9'd0);
    ask_point(10'd330, 9'd50);
    ask_point(10'd100, 9'd100);
    // zero focal lengths: sign of the numerator, or zero
    program_camera(16'd0, 16'd0, CFG_W'(16 * (FRAME_WIDTH - 1)), 16'd0, 16'd20);
    ask_point(10'd639, 9'd479);
    ask_point(10'd0, 9'd0);
    // window of zero searches nothing
    program_camera(RST_FOCAL_X, RST_FOCAL_Y, RST_CENTER_X, RST_CENTER_Y, 16'hFF00);
    ask_point(10'd0, 9'd0);
    drain_results();
    for (idx = int'(REG_WINDOW) + 1; idx < (1 << CIDX_W); idx++)
      cfg_write(idx[CIDX_W-1:0], 16'h0003);
    ask_point(10'd0, 9'd0);
    drain_results();
    cfg_write(REG_WINDOW, 16'd3);
    ask_point(10'd0, 9'd0);
  endtask

  task automatic random_sequence();
    int unsigned row, col, span, sel;
    int off, c;
    if ($urandom_range(0, 9) < 7) begin
      // a few pixels around a spot, then the query at the spot
      row = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 11) * 40
                                        : $urandom_range(0, FRAME_HEIGHT - 1);
      sel = $urandom_range(0, 9);
      if (sel < 2)
        col = $urandom_range(0, 15);
      else if (sel < 4)
        col = $urandom_range(FRAME_WIDTH - 16, FRAME_WIDTH - 1);
      else
        col = $urandom_range(0, FRAME_WIDTH - 1);
      span = int'(cam_win) + 2;
      repeat ($urandom_range(0, 3)) begin
        off = int'($urandom_range(0, 2 * span)) - int'(span);
        c   = int'(col) + off;
        if (c >= 0 && c < FRAME_WIDTH)
          put_depth(c[COL_W-1:0], row[ROW_W-1:0],
                    ($urandom_range(0, 7) == 0) ? '0 : DEPTH_W'($urandom_range(1, 65535)));
      end
      ask_point(col[COL_W-1:0], row[ROW_W-1:0]);
    end else begin
      send_beat(1'($urandom_range(0, 1)), COL_W'($urandom), ROW_W'($urandom),
                DEPTH_W'($urandom));
    end
  endtask

  task automatic test_random_traffic();
    int unsigned phase, target;
    logic [CFG_W-1:0] fx, fy, win;
    phase = 0;
    beats_counted = 0;
    while (beats_counted < RANDOM_BEATS) begin
      fx  = ($urandom_range(0, 1) != 0) ? CFG_W'($urandom) : CFG_W'($urandom_range(4000, 20000));
      fy  = ($urandom_range(0, 1) != 0) ? CFG_W'($urandom) : CFG_W'($urandom_range(4000, 20000));
      win = {8'($urandom), 8'($urandom_range(1, 30))};
      case (phase % 6)
        0: program_camera(RST_FOCAL_X, RST_FOCAL_Y, RST_CENTER_X, RST_CENTER_Y,
                          CFG_W'(RST_WINDOW));
        2: program_camera(fx, fy, CFG_W'($urandom), CFG_W'($urandom),
                          {8'($urandom), 8'($urandom_range(200, 255))});
        3: program_camera(fx, fy, CFG_W'($urandom), CFG_W'($urandom),
                          {8'($urandom), 8'($urandom_range(1, 4))});
        default: program_camera(fx, fy, CFG_W'($urandom), CFG_W'($urandom), win);
      endcase
      steady_flow = (phase % 4 == 3);
      target = beats_counted + 220;
      while (beats_counted < target) random_sequence();
      phase++;
    end
    steady_flow = 1'b0;
  endtask

  initial begin : result_sink
    int unsigned hold;
    out_tready = 1'b0;
    hold = 0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        out_tready <= 1'b0;
        hold--;
      end else begin
        out_tready <= 1'b1;
        if ($urandom_range(0, 3) == 0) hold = idle_len();
      end
    end
  end

  function automatic void check_field(input string name, input logic signed [63:0] want,
                                      input logic signed [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin : result_check
    point_rec_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_points.size() == 0) begin
        $error("result beat with no query waiting");
        fail_count++;
      end else begin
        want = pending_points.pop_front();
        check_field("status", want.status, out_tuser);
        check_field("point_x_mm", want.x_mm, $signed(out_tdata[31:0]));
        check_field("point_y_mm", want.y_mm, $signed(out_tdata[63:32]));
        check_field("point_z_mm", want.z_mm, out_tdata[79:64]);
        check_field("found_col", want.col, out_tdata[89:80]);
      end
    end
  end

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_frame_edges();
    test_register_extremes();
    test_random_traffic();
    drain_results();
    repeat (200) @(posedge clk);
    if (fail_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

// ===== depth_pixel_deprojection.f =====
design/dpd_pkg.sv
design/dpd_ctrl.sv
design/dpd_datapath.sv
design/depth_pixel_deprojection.sv
design/dpd_checker.sv
bench/testbench.sv
